// ===== src/jac_pkg.sv =====
// Shared types and constants for the Jacobi symbol unit.
// Used by jac_rem and jacobi_symbol_unit. It depends on nothing else.
`timescale 1ns / 1ps

package jac_pkg;

   // Sequencer states of the top level.
   typedef enum logic [1:0] {
      JAC_IDLE,
      JAC_REDUCE,
      JAC_LOOP,
      JAC_MOD
   } jac_state_type;

   // States of the shift-subtract remainder unit.
   typedef enum logic [1:0] {
      REM_IDLE,
      REM_UP,
      REM_DOWN
   } rem_state_type;

   // Codes of the two-bit signed result.
   localparam logic signed [1:0] SYM_ZERO = 2'sb00;
   localparam logic signed [1:0] SYM_POS  = 2'sb01;
   localparam logic signed [1:0] SYM_NEG  = 2'sb11;

   // Residues that decide a sign flip.
   localparam logic [2:0] MOD8_THREE = 3'd3;
   localparam logic [2:0] MOD8_FIVE  = 3'd5;
   localparam logic [1:0] MOD4_THREE = 2'd3;

endpackage

// ===== src/jacobi_symbol_unit.sv =====
// Top level of the Jacobi symbol unit: sequencer, operand registers and result.
// Depends on jac_pkg and jac_rem.
`timescale 1ns / 1ps

// Channel   Direction  Ports                                        Handshake
// request   in         req_numerator, req_denominator               start & !busy
// response  out        rsp_symbol, rsp_bad_denominator              rsp_valid, one cycle
//
// A bad denominator is answered straight from the idle state. Otherwise an
// item runs one remainder to bring the numerator into range, then one per
// swap, with a loop step for each stripped factor of two and each swap.
// All remainders run through the single shift-subtract unit.
// Reset clears the sequencer, the remainder unit's state and rsp_valid.
// The receiver cannot stall: rsp_valid is high for exactly one cycle per item,
// and a new item may be started in that same cycle.

module jacobi_symbol_unit
   import jac_pkg::*;
#(
   parameter int WORD_BITS = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic signed [WORD_BITS-1:0] req_numerator,
   input  logic signed [WORD_BITS-1:0] req_denominator,
   output logic                        rsp_valid,
   output logic signed [1:0]           rsp_symbol,
   output logic                        rsp_bad_denominator
);

   jac_state_type        state_ff, state_in;
   logic [WORD_BITS-1:0] a_ff, a_in;
   logic [WORD_BITS-1:0] n_ff, n_in;
   logic                 neg_ff, neg_in;
   logic                 flip_ff, flip_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic signed [1:0]    rsp_symbol_ff, rsp_symbol_in;
   logic                 rsp_bad_ff, rsp_bad_in;

   logic                 accept;
   logic                 bad_den;
   logic [WORD_BITS-1:0] num_bits;
   logic [WORD_BITS-1:0] num_mag;
   logic                 a_zero;
   logic                 rem_start;
   logic [WORD_BITS-1:0] rem_x;
   logic [WORD_BITS-1:0] rem_d;
   logic                 rem_done;
   logic [WORD_BITS-1:0] rem_r;

   assign accept   = start && (state_ff == JAC_IDLE);
   // The denominator must be positive and odd.
   assign bad_den  = req_denominator[WORD_BITS-1] || !req_denominator[0];
   assign num_bits = req_numerator;
   // A negative numerator is reduced through its magnitude; the most negative
   // value gives 2^(WORD_BITS-1), which is exact as an unsigned word.
   assign num_mag  = num_bits[WORD_BITS-1] ? (~num_bits + WORD_BITS'(1)) : num_bits;
   assign a_zero   = (a_ff == '0);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         JAC_IDLE: begin
            if (accept && !bad_den) state_in = JAC_REDUCE;
         end
         JAC_REDUCE: begin
            if (rem_done) state_in = JAC_LOOP;
         end
         JAC_LOOP: begin
            if (a_zero) begin
               state_in = JAC_IDLE;
            end else if (a_ff[0]) begin
               state_in = JAC_MOD;
            end
         end
         JAC_MOD: begin
            if (rem_done) state_in = JAC_LOOP;
         end
         default: state_in = JAC_IDLE;
      endcase
   end

   // Controls of the remainder unit. It is started once to bring the
   // numerator into range, then once after every swap.
   always_comb begin
      rem_start = 1'b0;
      rem_x     = n_ff;
      rem_d     = a_ff;
      case (state_ff)
         JAC_IDLE: begin
            rem_start = accept && !bad_den;
            rem_x     = num_mag;
            rem_d     = req_denominator;
         end
         JAC_LOOP: begin
            rem_start = !a_zero && a_ff[0];
         end
         default: begin
            rem_start = 1'b0;
         end
      endcase
   end

   // Operand, sign and result registers.
   always_comb begin
      a_in          = a_ff;
      n_in          = n_ff;
      neg_in        = neg_ff;
      flip_in       = flip_ff;
      rsp_valid_in  = 1'b0;
      rsp_symbol_in = rsp_symbol_ff;
      rsp_bad_in    = rsp_bad_ff;
      case (state_ff)
         JAC_IDLE: begin
            if (accept) begin
               n_in    = req_denominator;
               neg_in  = num_bits[WORD_BITS-1];
               flip_in = 1'b0;
               if (bad_den) begin
                  rsp_valid_in  = 1'b1;
                  rsp_symbol_in = SYM_ZERO;
                  rsp_bad_in    = 1'b1;
               end
            end
         end
         JAC_REDUCE: begin
            if (rem_done) begin
               if (neg_ff && (rem_r != '0)) begin
                  a_in = n_ff - rem_r;
               end else begin
                  a_in = rem_r;
               end
            end
         end
         JAC_LOOP: begin
            if (a_zero) begin
               // The symbol is the sign only when the gcd came out as one.
               rsp_valid_in = 1'b1;
               rsp_bad_in   = 1'b0;
               if (n_ff == WORD_BITS'(1)) begin
                  rsp_symbol_in = flip_ff ? SYM_NEG : SYM_POS;
               end else begin
                  rsp_symbol_in = SYM_ZERO;
               end
            end else if (!a_ff[0]) begin
               // Each factor of two flips the sign when n is 3 or 5 mod 8.
               a_in = a_ff >> 1;
               if (n_ff[2:0] inside {MOD8_THREE, MOD8_FIVE}) flip_in = !flip_ff;
            end else begin
               // Reciprocity: swap, flipping when both are 3 mod 4. The new
               // a is loaded when the remainder unit finishes.
               n_in = a_ff;
               if ((a_ff[1:0] == MOD4_THREE) && (n_ff[1:0] == MOD4_THREE)) begin
                  flip_in = !flip_ff;
               end
            end
         end
         JAC_MOD: begin
            if (rem_done) a_in = rem_r;
         end
         default: begin
            a_in = a_ff;
         end
      endcase
   end

   jac_rem #(
      .WORD_BITS (WORD_BITS)
   ) u_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (rem_start),
      .dividend  (rem_x),
      .divisor   (rem_d),
      .done      (rem_done),
      .remainder (rem_r)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= JAC_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff          <= a_in;
      n_ff          <= n_in;
      neg_ff        <= neg_in;
      flip_ff       <= flip_in;
      rsp_symbol_ff <= rsp_symbol_in;
      rsp_bad_ff    <= rsp_bad_in;
   end

   assign busy                = (state_ff != JAC_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_symbol          = rsp_symbol_ff;
   assign rsp_bad_denominator = rsp_bad_ff;

endmodule

// ===== src/jac_rem.sv =====
// Iterative remainder unit: x mod d by aligning d under x, then one
// compare and subtract per cycle. Depends on jac_pkg.
`timescale 1ns / 1ps

module jac_rem
   import jac_pkg::*;
#(
   parameter int WORD_BITS = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [WORD_BITS-1:0] dividend,
   input  logic [WORD_BITS-1:0] divisor,
   output logic                 done,
   output logic [WORD_BITS-1:0] remainder
);

   localparam int CNT_BITS = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;

   rem_state_type        state_ff, state_in;
   logic [WORD_BITS-1:0] x_ff, x_in;
   logic [WORD_BITS-1:0] d_ff, d_in;
   logic [CNT_BITS-1:0]  k_ff, k_in;
   logic [WORD_BITS-1:0] x_step;
   logic                 fits;
   logic                 grow;

   // The divisor may double only while it stays at or below x / 2.
   assign grow   = (d_ff <= (x_ff >> 1));
   assign fits   = (x_ff >= d_ff);
   assign x_step = fits ? (x_ff - d_ff) : x_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         REM_IDLE: begin
            if (start) state_in = REM_UP;
         end
         REM_UP: begin
            if (!grow) state_in = REM_DOWN;
         end
         REM_DOWN: begin
            if (k_ff == '0) state_in = REM_IDLE;
         end
         default: state_in = REM_IDLE;
      endcase
   end

   always_comb begin
      x_in = x_ff;
      d_in = d_ff;
      k_in = k_ff;
      case (state_ff)
         REM_IDLE: begin
            if (start) begin
               x_in = dividend;
               d_in = divisor;
               k_in = '0;
            end
         end
         REM_UP: begin
            if (grow) begin
               d_in = d_ff << 1;
               k_in = k_ff + CNT_BITS'(1);
            end
         end
         REM_DOWN: begin
            if (k_ff != '0) begin
               x_in = x_step;
               d_in = d_ff >> 1;
               k_in = k_ff - CNT_BITS'(1);
            end
         end
         default: begin
            x_in = x_ff;
         end
      endcase
   end

   always_comb begin
      done      = (state_ff == REM_DOWN) && (k_ff == '0);
      remainder = x_step;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= REM_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      d_ff <= d_in;
      k_ff <= k_in;
   end

endmodule
